// ===== design/psw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_pkg: shared types and constants for the periodic particle step
// Payload structs, configuration register indexes, reset values and the
// reciprocal constants used for division by ten and by two hundred.
// ----------------------------------------------------------------------------
package psw_pkg;

    localparam int GRID_MAX   = 1024;
    localparam int CELL_W     = $clog2(GRID_MAX);
    localparam int GRID_W     = CELL_W + 1;
    localparam int DATA_W     = 32;
    localparam int SIDE_W     = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP_CELL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_ROW      = 3'd4;

    localparam logic [SIDE_W-1:0] SIDE_LENGTH_RESET   = 31'd65536;
    localparam logic [SIDE_W-1:0] RECIP_CELL_RESET    = 31'd65536;
    localparam logic [GRID_W-1:0] GRID_SIDE_RESET     = 11'd1;
    localparam logic [CELL_W-1:0] FIRST_ROW_RESET     = 10'd0;
    localparam logic [CELL_W-1:0] LAST_ROW_RESET      = 10'd0;

    // floor(u / 10) = (u * MAGIC_DIV10) >> 35 and
    // floor(u / 200) = (u * MAGIC_DIV200) >> 39 for any 32-bit unsigned u
    localparam logic [31:0] MAGIC_DIV10    = 32'hCCCC_CCCD;
    localparam int          SHIFT_DIV10    = 35;
    localparam logic [31:0] MAGIC_DIV200   = 32'hA3D7_0A3E;
    localparam int          SHIFT_DIV200   = 39;

    // Offset-binary correction: 2^31 = 10*DIV10_BIAS + DIV10_REM, same for 200
    localparam longint      HALF_RANGE     = 64'sd2147483648;
    localparam int          DIV10_BIAS     = int'(HALF_RANGE / 10);
    localparam int          DIV10_REM      = int'(HALF_RANGE % 10);
    localparam int          DIV200_BIAS    = int'(HALF_RANGE / 200);
    localparam int          DIV200_REM     = int'(HALF_RANGE % 200);

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
        logic signed [DATA_W-1:0] acc_x;
        logic signed [DATA_W-1:0] acc_y;
        logic [CELL_W-1:0]        prev_cell_x;
        logic [CELL_W-1:0]        prev_cell_y;
        logic                     dead;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] new_pos_x;
        logic signed [DATA_W-1:0] new_pos_y;
        logic signed [DATA_W-1:0] new_vel_x;
        logic signed [DATA_W-1:0] new_vel_y;
        logic [CELL_W-1:0]        cell_x;
        logic [CELL_W-1:0]        cell_y;
        logic                     cell_changed;
        logic                     leaves_domain;
        logic                     too_fast;
    } out_item_t;

endpackage

// ===== design/particle_step_periodic_wrap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_step_periodic_wrap: kinematic particle step with periodic wrap
// Moves one particle per transfer in signed Q16.16, wraps it into the domain,
// finds its grid cell, flags cell and domain changes and updates velocity.
// ----------------------------------------------------------------------------
// Structure: five pipeline stages, then the output register (out_valid).
// Throughput: one particle per cycle while out_ready is high; each stage
//   advances whenever the stage after it is empty or moving, so bubbles
//   close up during a stall.
// Reset: clears all stage valid bits and loads the registers with their
//   reset values (side 1.0, inverse cell 1.0, one cell, rows 0..0).
// ----------------------------------------------------------------------------
module particle_step_periodic_wrap (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  psw_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output psw_pkg::out_item_t                  out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [psw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psw_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Stage 1: reciprocal products -> raw offset-binary quotients
    typedef struct packed {
        psw_pkg::in_item_t item;
        logic [1:0][28:0]  quo_v10;
        logic [1:0][24:0]  quo_a200;
        logic [1:0][28:0]  quo_a10;
    } st1_t;

    // Stage 2: signed floor quotients and the carry of the remainders
    typedef struct packed {
        psw_pkg::in_item_t item;
        logic [1:0][28:0]  q_v10;
        logic [1:0][24:0]  q_a200;
        logic [1:0]        carry;
        logic [1:0][28:0]  q_a10;
    } st2_t;

    // Stage 3: unwrapped position and saturated velocity
    typedef struct packed {
        psw_pkg::in_item_t item;
        logic [1:0][33:0]  sum;
        logic [1:0][31:0]  vel;
    } st3_t;

    // Stage 4: wrapped and clamped position
    typedef struct packed {
        psw_pkg::in_item_t item;
        logic [1:0][30:0]  pos;
        logic [1:0]        fast;
        logic [1:0][31:0]  vel;
    } st4_t;

    // Stage 5: unclamped cell index
    typedef struct packed {
        psw_pkg::in_item_t item;
        logic [1:0][29:0]  cell_idx;
        logic [1:0][30:0]  pos;
        logic [1:0]        fast;
        logic [1:0][31:0]  vel;
    } st5_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [psw_pkg::SIDE_W-1:0] side_length_reg;
    logic [psw_pkg::SIDE_W-1:0] recip_cell_reg;
    logic [psw_pkg::GRID_W-1:0] grid_side_reg;
    logic [psw_pkg::CELL_W-1:0] first_row_reg;
    logic [psw_pkg::CELL_W-1:0] last_row_reg;

    // The register file never stalls a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_length_reg <= psw_pkg::SIDE_LENGTH_RESET;
            recip_cell_reg  <= psw_pkg::RECIP_CELL_RESET;
            grid_side_reg   <= psw_pkg::GRID_SIDE_RESET;
            first_row_reg   <= psw_pkg::FIRST_ROW_RESET;
            last_row_reg    <= psw_pkg::LAST_ROW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                psw_pkg::CFG_SIDE_LENGTH: side_length_reg <= cfg_data[psw_pkg::SIDE_W-1:0];
                psw_pkg::CFG_RECIP_CELL:  recip_cell_reg  <= cfg_data[psw_pkg::SIDE_W-1:0];
                psw_pkg::CFG_GRID_SIDE:   grid_side_reg   <= cfg_data[psw_pkg::GRID_W-1:0];
                psw_pkg::CFG_FIRST_ROW:   first_row_reg   <= cfg_data[psw_pkg::CELL_W-1:0];
                psw_pkg::CFG_LAST_ROW:    last_row_reg    <= cfg_data[psw_pkg::CELL_W-1:0];
                default:                  ; // drop writes to unmapped indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or when the
    // stage after it loads in the same cycle.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic out_valid_reg;
    logic en1, en2, en3, en4, en5, en_out;

    st1_t s1_reg, s1_next;
    st2_t s2_reg, s2_next;
    st3_t s3_reg, s3_next;
    st4_t s4_reg, s4_next;
    st5_t s5_reg, s5_next;
    psw_pkg::out_item_t out_reg, out_next;

    always_comb
    begin
        en_out   = !out_valid_reg || out_ready;
        en5      = !s5_valid_reg  || en_out;
        en4      = !s4_valid_reg  || en5;
        en3      = !s3_valid_reg  || en4;
        en2      = !s2_valid_reg  || en3;
        en1      = !s1_valid_reg  || en2;
        in_ready = en1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)    s1_valid_reg  <= in_valid;
            if (en2)    s2_valid_reg  <= s1_valid_reg;
            if (en3)    s3_valid_reg  <= s2_valid_reg;
            if (en4)    s4_valid_reg  <= s3_valid_reg;
            if (en5)    s5_valid_reg  <= s4_valid_reg;
            if (en_out) out_valid_reg <= s5_valid_reg;
        end
    end

    // Payload registers carry no reset; the valid bits qualify them.
    always_ff @(posedge clk)
    begin
        if (en1)    s1_reg  <= s1_next;
        if (en2)    s2_reg  <= s2_next;
        if (en3)    s3_reg  <= s3_next;
        if (en4)    s4_reg  <= s4_next;
        if (en5)    s5_reg  <= s5_next;
        if (en_out) out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ------------------------------------------------------------------
    // Stage 1: flip the sign bit to get offset-binary values, then multiply
    // by the reciprocals of 10 and 200.
    // ------------------------------------------------------------------
    logic [1:0][31:0] in_vel, in_acc;
    logic [1:0][31:0] in_vel_u, in_acc_u;
    logic [1:0][63:0] prod_v10, prod_a200, prod_a10;

    always_comb
    begin
        in_vel[0] = in_data.vel_x;
        in_vel[1] = in_data.vel_y;
        in_acc[0] = in_data.acc_x;
        in_acc[1] = in_data.acc_y;
        s1_next.item = in_data;
        for (int ax = 0; ax < 2; ax++)
        begin
            in_vel_u[ax]  = {~in_vel[ax][31], in_vel[ax][30:0]};
            in_acc_u[ax]  = {~in_acc[ax][31], in_acc[ax][30:0]};
            prod_v10[ax]  = 64'(in_vel_u[ax]) * 64'(psw_pkg::MAGIC_DIV10);
            prod_a200[ax] = 64'(in_acc_u[ax]) * 64'(psw_pkg::MAGIC_DIV200);
            prod_a10[ax]  = 64'(in_acc_u[ax]) * 64'(psw_pkg::MAGIC_DIV10);
            s1_next.quo_v10[ax]  = prod_v10[ax][63:psw_pkg::SHIFT_DIV10];
            s1_next.quo_a200[ax] = prod_a200[ax][63:psw_pkg::SHIFT_DIV200];
            s1_next.quo_a10[ax]  = prod_a10[ax][63:psw_pkg::SHIFT_DIV10];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: remainders, removal of the 2^31 offset, and the carry of
    // floor((20*v + a) / 200) = floor(v/10) + floor(a/200) + carry.
    // ------------------------------------------------------------------
    logic [1:0][31:0] s1_vel, s1_acc, s1_vel_u, s1_acc_u;
    logic [1:0][31:0] rem_v10_full, rem_a200_full, rem_a10_full;
    logic [1:0][3:0]  rem_v10, rem_a10, rv;
    logic [1:0][7:0]  rem_a200, ra;

    always_comb
    begin
        s1_vel[0] = s1_reg.item.vel_x;
        s1_vel[1] = s1_reg.item.vel_y;
        s1_acc[0] = s1_reg.item.acc_x;
        s1_acc[1] = s1_reg.item.acc_y;
        s2_next.item = s1_reg.item;
        for (int ax = 0; ax < 2; ax++)
        begin
            s1_vel_u[ax] = {~s1_vel[ax][31], s1_vel[ax][30:0]};
            s1_acc_u[ax] = {~s1_acc[ax][31], s1_acc[ax][30:0]};
            rem_v10_full[ax]  = s1_vel_u[ax] - 32'(s1_reg.quo_v10[ax]) * 32'd10;
            rem_a200_full[ax] = s1_acc_u[ax] - 32'(s1_reg.quo_a200[ax]) * 32'd200;
            rem_a10_full[ax]  = s1_acc_u[ax] - 32'(s1_reg.quo_a10[ax]) * 32'd10;
            rem_v10[ax]  = rem_v10_full[ax][3:0];
            rem_a200[ax] = rem_a200_full[ax][7:0];
            rem_a10[ax]  = rem_a10_full[ax][3:0];

            if (rem_v10[ax] >= 4'(psw_pkg::DIV10_REM))
            begin
                s2_next.q_v10[ax] = s1_reg.quo_v10[ax] - 29'(psw_pkg::DIV10_BIAS);
                rv[ax]            = rem_v10[ax] - 4'(psw_pkg::DIV10_REM);
            end
            else
            begin
                s2_next.q_v10[ax] = s1_reg.quo_v10[ax] - 29'(psw_pkg::DIV10_BIAS + 1);
                rv[ax]            = rem_v10[ax] + 4'(10 - psw_pkg::DIV10_REM);
            end

            if (rem_a200[ax] >= 8'(psw_pkg::DIV200_REM))
            begin
                s2_next.q_a200[ax] = s1_reg.quo_a200[ax] - 25'(psw_pkg::DIV200_BIAS);
                ra[ax]             = rem_a200[ax] - 8'(psw_pkg::DIV200_REM);
            end
            else
            begin
                s2_next.q_a200[ax] = s1_reg.quo_a200[ax] - 25'(psw_pkg::DIV200_BIAS + 1);
                ra[ax]             = rem_a200[ax] + 8'(200 - psw_pkg::DIV200_REM);
            end

            if (rem_a10[ax] >= 4'(psw_pkg::DIV10_REM))
                s2_next.q_a10[ax] = s1_reg.quo_a10[ax] - 29'(psw_pkg::DIV10_BIAS);
            else
                s2_next.q_a10[ax] = s1_reg.quo_a10[ax] - 29'(psw_pkg::DIV10_BIAS + 1);

            s2_next.carry[ax] = (9'(rv[ax]) * 9'd20 + 9'(ra[ax])) >= 9'd200;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: add the displacement to the position; add a/10 to the
    // velocity and saturate to 32 bits.
    // ------------------------------------------------------------------
    logic [1:0][31:0]  s2_pos, s2_vel;
    logic signed [32:0] vel_sum [2];

    always_comb
    begin
        s2_pos[0] = s2_reg.item.pos_x;
        s2_pos[1] = s2_reg.item.pos_y;
        s2_vel[0] = s2_reg.item.vel_x;
        s2_vel[1] = s2_reg.item.vel_y;
        s3_next.item = s2_reg.item;
        for (int ax = 0; ax < 2; ax++)
        begin
            s3_next.sum[ax] = 34'($signed(s2_pos[ax])) + 34'($signed(s2_reg.q_v10[ax]))
                            + 34'($signed(s2_reg.q_a200[ax])) + 34'(s2_reg.carry[ax]);
            vel_sum[ax] = 33'($signed(s2_vel[ax])) + 33'($signed(s2_reg.q_a10[ax]));
            if (vel_sum[ax][32] != vel_sum[ax][31])
                s3_next.vel[ax] = vel_sum[ax][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else
                s3_next.vel[ax] = vel_sum[ax][31:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: single periodic wrap, then clamp and flag what one wrap
    // could not bring into [0, side).
    // ------------------------------------------------------------------
    logic [psw_pkg::SIDE_W-1:0] side_eff;
    logic signed [33:0]         side_s;
    logic signed [33:0]         sum_s  [2];
    logic signed [33:0]         wrap_s [2];

    always_comb
    begin
        side_eff = (side_length_reg == '0) ? psw_pkg::SIDE_W'(1) : side_length_reg;
        side_s   = $signed({3'b000, side_eff});
        s4_next.item = s3_reg.item;
        s4_next.vel  = s3_reg.vel;
        for (int ax = 0; ax < 2; ax++)
        begin
            sum_s[ax] = $signed(s3_reg.sum[ax]);
            if (sum_s[ax] >= side_s)
                wrap_s[ax] = sum_s[ax] - side_s;
            else if (sum_s[ax] < 34'sd0)
                wrap_s[ax] = sum_s[ax] + side_s;
            else
                wrap_s[ax] = sum_s[ax];

            if (wrap_s[ax] < 34'sd0)
            begin
                s4_next.pos[ax]  = '0;
                s4_next.fast[ax] = 1'b1;
            end
            else if (wrap_s[ax] >= side_s)
            begin
                s4_next.pos[ax]  = side_eff - psw_pkg::SIDE_W'(1);
                s4_next.fast[ax] = 1'b1;
            end
            else
            begin
                s4_next.pos[ax]  = wrap_s[ax][30:0];
                s4_next.fast[ax] = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: cell = integer part of pos * recip_cell (Q32.32 product)
    // ------------------------------------------------------------------
    logic [1:0][61:0] cell_prod;

    always_comb
    begin
        s5_next.item = s4_reg.item;
        s5_next.pos  = s4_reg.pos;
        s5_next.fast = s4_reg.fast;
        s5_next.vel  = s4_reg.vel;
        for (int ax = 0; ax < 2; ax++)
        begin
            cell_prod[ax]        = 62'(s4_reg.pos[ax]) * 62'(recip_cell_reg);
            s5_next.cell_idx[ax] = cell_prod[ax][61:32];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: clamp the cell to the grid, compare with the previous
    // cell, check the owned rows, pick the velocity and pass dead
    // particles through untouched.
    // ------------------------------------------------------------------
    logic [psw_pkg::GRID_W-1:0] grid_eff;
    logic [psw_pkg::GRID_W-1:0] grid_lim;
    logic [1:0][psw_pkg::CELL_W-1:0] cell_new;
    logic changed, leaves;

    always_comb
    begin
        if (grid_side_reg == '0)
            grid_eff = psw_pkg::GRID_W'(1);
        else if (grid_side_reg > psw_pkg::GRID_W'(psw_pkg::GRID_MAX))
            grid_eff = psw_pkg::GRID_W'(psw_pkg::GRID_MAX);
        else
            grid_eff = grid_side_reg;
        grid_lim = grid_eff - psw_pkg::GRID_W'(1);

        for (int ax = 0; ax < 2; ax++)
        begin
            if (s5_reg.cell_idx[ax] > 30'(grid_lim))
                cell_new[ax] = grid_lim[psw_pkg::CELL_W-1:0];
            else
                cell_new[ax] = s5_reg.cell_idx[ax][psw_pkg::CELL_W-1:0];
        end

        changed = (cell_new[0] != s5_reg.item.prev_cell_x)
               || (cell_new[1] != s5_reg.item.prev_cell_y);
        leaves  = changed && ((cell_new[1] < first_row_reg) || (cell_new[1] > last_row_reg));

        if (s5_reg.item.dead)
        begin
            out_next.new_pos_x     = s5_reg.item.pos_x;
            out_next.new_pos_y     = s5_reg.item.pos_y;
            out_next.new_vel_x     = s5_reg.item.vel_x;
            out_next.new_vel_y     = s5_reg.item.vel_y;
            out_next.cell_x        = s5_reg.item.prev_cell_x;
            out_next.cell_y        = s5_reg.item.prev_cell_y;
            out_next.cell_changed  = 1'b0;
            out_next.leaves_domain = 1'b0;
            out_next.too_fast      = 1'b0;
        end
        else
        begin
            out_next.new_pos_x     = {1'b0, s5_reg.pos[0]};
            out_next.new_pos_y     = {1'b0, s5_reg.pos[1]};
            // Hold the velocity when the particle moves to a foreign row.
            out_next.new_vel_x     = leaves ? s5_reg.item.vel_x : s5_reg.vel[0];
            out_next.new_vel_y     = leaves ? s5_reg.item.vel_y : s5_reg.vel[1];
            out_next.cell_x        = cell_new[0];
            out_next.cell_y        = cell_new[1];
            out_next.cell_changed  = changed;
            out_next.leaves_domain = leaves;
            out_next.too_fast      = s5_reg.fast[0] || s5_reg.fast[1];
        end
    end

endmodule

// ===== design/psw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_checker: port-level checks for the periodic particle step
// Watches the transfers on both channels and the result flags.
// ----------------------------------------------------------------------------
module psw_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input psw_pkg::out_item_t out_data
);

    // A stalled result holds its valid and its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // A domain exit is always a cell change.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.leaves_domain |-> out_data.cell_changed)
        else $error("leaves_domain without cell_changed");

    // A clamped wrap only comes from a live particle, so the position is
    // inside the domain and never negative.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.too_fast |-> !out_data.new_pos_x[31] && !out_data.new_pos_y[31])
        else $error("too_fast with a negative position");

    // With the sink ready throughout, an accepted particle reaches the output register and raises out_valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready
            ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("result missing after pipeline latency");

endmodule

bind particle_step_periodic_wrap psw_checker u_psw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
